@@ src/token_bucket_policer_macros.svh @@
// Assertion helpers used by the policer RTL.
// Both expect i_clk and i_rst_n in the scope of the module that uses them.
`ifndef TOKEN_BUCKET_POLICER_MACROS_SVH
`define TOKEN_BUCKET_POLICER_MACROS_SVH

// Same-cycle implication, idle during reset
`define TBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, idle during reset
`define TBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tbp_pkg.sv @@
package tbp_pkg;

    // Field widths
    localparam int PKT_W      = 16;
    localparam int TIME_W     = 64;
    localparam int RATE_W     = 40;
    localparam int LEVEL_W    = 32;
    localparam int REFILL_W   = 42;
    localparam int REM_W      = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    // Refill product: (now - anchor) * rate + anchor remainder
    localparam int E_SPLIT = 32;                 // split of elapsed time
    localparam int R_SPLIT = 20;                 // split of rate
    localparam int PP_W    = E_SPLIT + R_SPLIT;  // one partial product
    localparam int PS_W    = PP_W + R_SPLIT;     // sum of two partial products
    localparam int PROD_W  = TIME_W + RATE_W;    // full product

    // Division by 8,000,000 = 2^9 * 15625: low bits pass, rest goes by digits
    localparam int LOW_W   = 9;
    localparam int DIG_W   = 18;
    localparam int DIG_N   = 5;
    localparam int WORK_W  = DIG_W * DIG_N;
    localparam int TOP_W   = PROD_W - LOW_W - WORK_W;
    localparam int DREM_W  = 14;
    localparam int NUM_W   = DREM_W + DIG_W;
    localparam int RECIP_W = 33;
    localparam int DIV_SH  = 46;
    localparam int QUO_W   = 82;

    localparam logic [DREM_W-1:0]  DIV_D     = 14'd15625;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 33'd4503599628;  // ceil(2^46 / 15625)

    localparam logic [REM_W-1:0] BPB_MICROS = 23'd8000000;

    // Largest numerator that fits 64 bits, as quotient and remainder
    localparam logic [QUO_W-1:0] REFILL_MAX     = 82'd2305843009213;
    localparam logic [REM_W-1:0] REFILL_MAX_REM = 23'd5551615;

    typedef enum logic [1:0] {
        OUT_ALLOW   = 2'd0,
        OUT_LIMITED = 2'd1,
        OUT_GATE    = 2'd2,
        OUT_ARITH   = 2'd3
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATE  = 2'd0,
        CFG_RATE  = 2'd1,
        CFG_BURST = 2'd2
    } t_cfg_idx;

    // Per-packet fields that ride along the pipeline
    typedef struct packed {
        logic [PKT_W-1:0]  pkt;
        logic [TIME_W-1:0] now;
    } t_side;

    // Division work word: partial remainder, undivided digits, quotient so far
    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [WORK_W-1:0] work;
        logic [WORK_W-1:0] quo;
        logic [LOW_W-1:0]  low;
        t_side             side;
    } t_div;

    // Refill reference held by the bucket, read by the product pipeline
    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [TIME_W-1:0] t0;
        logic [REM_W-1:0]  rem0;
    } t_anchor;

endpackage

@@ src/tbp_if.sv @@
// Packet channel
interface tbp_pkt_if;
    import tbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [PKT_W-1:0]  packet_bytes;
    logic [TIME_W-1:0] now_micros;

    modport source (output valid, output packet_bytes, output now_micros, input ready);
    modport sink   (input valid, input packet_bytes, input now_micros, output ready);
endinterface

// Verdict channel
interface tbp_res_if;
    import tbp_pkg::*;

    logic                valid;
    logic                ready;
    logic                allowed;
    logic [1:0]          outcome;
    logic [LEVEL_W-1:0]  tokens_before;
    logic [LEVEL_W-1:0]  tokens_after;
    logic [REFILL_W-1:0] refill_bytes;

    modport source (output valid, output allowed, output outcome, output tokens_before,
                    output tokens_after, output refill_bytes, input ready);
    modport sink   (input valid, input allowed, input outcome, input tokens_before,
                    input tokens_after, input refill_bytes, output ready);
endinterface

@@ src/tbp_mul.sv @@
module tbp_mul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tbp_pkt_if.sink          i_pkt,
    input  tbp_pkg::t_anchor i_anc,
    output logic             o_valid,
    output tbp_pkg::t_div    o_data,
    input  logic             i_ready
);
    import tbp_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    t_side             r_side1, r_side2, r_side3;
    logic [TIME_W-1:0] r_e1;
    logic [PP_W-1:0]   r_p00, r_p01, r_p10, r_p11;
    logic [PS_W-1:0]   r_slo, r_shi;
    t_div              r_d4;

    logic [TIME_W-1:0] n_e;
    logic [PROD_W-1:0] n_b;
    t_div              n_d4;

    // Stall chain: a stage loads when empty or when its successor moves
    assign rdy4 = !r_v4 || i_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign i_pkt.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_pkt.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage 1: time since the anchor
    assign n_e = i_pkt.now_micros - i_anc.t0;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_side1.pkt <= i_pkt.packet_bytes;
            r_side1.now <= i_pkt.now_micros;
            r_e1        <= n_e;
        end
    end

    // Stage 2: four partial products
    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_side2 <= r_side1;
            r_p00   <= PP_W'(r_e1[E_SPLIT-1:0]) * PP_W'(i_anc.rate[R_SPLIT-1:0]);
            r_p01   <= PP_W'(r_e1[E_SPLIT-1:0]) * PP_W'(i_anc.rate[RATE_W-1:R_SPLIT]);
            r_p10   <= PP_W'(r_e1[TIME_W-1:E_SPLIT]) * PP_W'(i_anc.rate[R_SPLIT-1:0]);
            r_p11   <= PP_W'(r_e1[TIME_W-1:E_SPLIT]) * PP_W'(i_anc.rate[RATE_W-1:R_SPLIT]);
        end
    end

    // Stage 3: fold pairs
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_side3 <= r_side2;
            r_slo   <= PS_W'(r_p00) + (PS_W'(r_p01) << R_SPLIT);
            r_shi   <= PS_W'(r_p10) + (PS_W'(r_p11) << R_SPLIT);
        end
    end

    // Stage 4: full numerator, cut into division fields
    always_comb begin
        n_b       = PROD_W'(r_slo) + (PROD_W'(r_shi) << E_SPLIT) + PROD_W'(i_anc.rem0);
        n_d4.rem  = DREM_W'(n_b[PROD_W-1 -: TOP_W]);
        n_d4.work = n_b[LOW_W +: WORK_W];
        n_d4.quo  = '0;
        n_d4.low  = n_b[LOW_W-1:0];
        n_d4.side = r_side3;
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_d4 <= n_d4;
        end
    end

    assign o_valid = r_v4;
    assign o_data  = r_d4;

endmodule

@@ src/tbp_div_step.sv @@
module tbp_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tbp_pkg::t_div i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output tbp_pkg::t_div o_data
);
    import tbp_pkg::*;

    logic r_va, r_vb;
    logic rdy_a, rdy_b;

    t_div             r_a, r_b;
    logic [NUM_W-1:0] r_num;

    logic [NUM_W-1:0]         n_num;
    logic [NUM_W+RECIP_W-1:0] n_prod;
    logic [DIG_W-1:0]         n_q;
    logic [NUM_W-1:0]         n_rfull;
    t_div                     n_a, n_b;

    assign rdy_b   = !r_vb || i_ready;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    // Stage a: next digit by reciprocal multiply (exact over the digit range)
    always_comb begin
        n_num    = {i_data.rem, i_data.work[WORK_W-1 -: DIG_W]};
        n_prod   = (NUM_W+RECIP_W)'(n_num) * (NUM_W+RECIP_W)'(DIV_RECIP);
        n_q      = n_prod[DIV_SH +: DIG_W];
        n_a      = i_data;
        n_a.work = i_data.work << DIG_W;
        n_a.quo  = {i_data.quo[WORK_W-DIG_W-1:0], n_q};
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a   <= n_a;
            r_num <= n_num;
        end
    end

    // Stage b: partial remainder for the next digit
    always_comb begin
        n_rfull = r_num - NUM_W'(r_a.quo[DIG_W-1:0]) * NUM_W'(DIV_D);
        n_b     = r_a;
        n_b.rem = n_rfull[DREM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_vb;
    assign o_data  = r_b;

endmodule

@@ src/tbp_bucket.sv @@
`include "token_bucket_policer_macros.svh"

module tbp_bucket (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  tbp_pkg::t_div                  i_data,
    output tbp_pkg::t_anchor               o_anc,
    tbp_res_if.source                      o_res
);
    import tbp_pkg::*;

    // Configuration
    logic               r_gate;
    logic [RATE_W-1:0]  r_rate;
    logic [LEVEL_W-1:0] r_burst;

    // Bucket state and refill anchor
    logic [LEVEL_W-1:0] r_level;
    logic [TIME_W-1:0]  r_last;
    logic [QUO_W-1:0]   r_qlast;
    logic [REM_W-1:0]   r_rem;
    logic [TIME_W-1:0]  r_t0;
    logic [REM_W-1:0]   r_rem0;

    // Result register
    logic                r_ovalid;
    logic                r_allowed;
    t_outcome            r_outcome;
    logic [LEVEL_W-1:0]  r_before;
    logic [LEVEL_W-1:0]  r_after;
    logic [REFILL_W-1:0] r_refill;

    logic                fin_fire;
    logic [QUO_W-1:0]    n_q;
    logic [REM_W-1:0]    n_r;
    logic [QUO_W-1:0]    n_diff;
    logic                n_back;
    logic                n_ovf;
    logic                n_reject;
    logic [LEVEL_W-1:0]  n_room;
    logic [LEVEL_W-1:0]  n_added;
    logic [LEVEL_W-1:0]  n_level;
    logic [LEVEL_W-1:0]  n_pkt;
    logic                n_limited;
    logic [LEVEL_W-1:0]  n_new_level;
    logic                n_commit;
    t_outcome            n_outcome;
    logic [LEVEL_W-1:0]  n_after;
    logic [REFILL_W-1:0] n_refill;

    assign o_ready  = !r_ovalid || o_res.ready;
    assign fin_fire = i_valid && o_ready;

    assign o_anc.rate = r_rate;
    assign o_anc.t0   = r_t0;
    assign o_anc.rem0 = r_rem0;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate  <= 1'b0;
            r_rate  <= '0;
            r_burst <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GATE:  r_gate  <= i_cfg_data[0];
                CFG_RATE:  r_rate  <= i_cfg_data[RATE_W-1:0];
                CFG_BURST: r_burst <= i_cfg_data[LEVEL_W-1:0];
                default:   r_gate  <= r_gate;
            endcase
        end
    end

    // Verdict: refill is the quotient step since the last committed beat
    always_comb begin
        n_q      = i_data.quo[QUO_W-1:0];
        n_r      = {i_data.rem, i_data.low};
        n_diff   = n_q - r_qlast;
        n_back   = i_data.side.now < r_last;
        n_ovf    = (n_diff > REFILL_MAX) || ((n_diff == REFILL_MAX) && (n_r > REFILL_MAX_REM));
        n_reject = r_gate || n_back || n_ovf;

        n_room  = (r_burst > r_level) ? (r_burst - r_level) : '0;
        n_added = ((n_diff[QUO_W-1:LEVEL_W] != '0) || (n_diff[LEVEL_W-1:0] >= n_room))
                  ? n_room : n_diff[LEVEL_W-1:0];
        n_level = r_level + n_added;

        n_pkt       = LEVEL_W'(i_data.side.pkt);
        n_limited   = n_pkt > n_level;
        n_new_level = n_limited ? n_level : (n_level - n_pkt);

        if (r_gate) begin
            n_outcome = OUT_GATE;
        end else if (n_back || n_ovf) begin
            n_outcome = OUT_ARITH;
        end else if (n_limited) begin
            n_outcome = OUT_LIMITED;
        end else begin
            n_outcome = OUT_ALLOW;
        end

        n_after  = n_reject ? r_level : n_new_level;
        n_refill = n_reject ? '0 : n_diff[REFILL_W-1:0];
        n_commit = fin_fire && !n_reject;
    end

    // Bucket state; a rate write moves the anchor to the last refill point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_last  <= '0;
            r_qlast <= '0;
            r_rem   <= '0;
            r_t0    <= '0;
            r_rem0  <= '0;
        end else begin
            if (n_commit) begin
                r_level <= n_new_level;
                r_last  <= i_data.side.now;
                r_qlast <= n_q;
                r_rem   <= n_r;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_RATE)) begin
                r_t0    <= r_last;
                r_rem0  <= r_rem;
                r_qlast <= '0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (o_ready) begin
            r_ovalid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_fire) begin
            r_allowed <= (n_outcome == OUT_ALLOW);
            r_outcome <= n_outcome;
            r_before  <= r_level;
            r_after   <= n_after;
            r_refill  <= n_refill;
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.allowed       = r_allowed;
    assign o_res.outcome       = r_outcome;
    assign o_res.tokens_before = r_before;
    assign o_res.tokens_after  = r_after;
    assign o_res.refill_bytes  = r_refill;

    `TBP_ASSERT_NXT(a_level_bound, n_commit, (r_level <= $past(r_burst)) || (r_level <= $past(r_level)), "level grew past burst")
    `TBP_ASSERT_NXT(a_reject_holds, fin_fire && !n_commit, $stable(r_last) && $stable(r_level) && $stable(r_rem), "rejected beat changed state")
    `TBP_ASSERT_NXT(a_rate_anchor, i_cfg_we && (i_cfg_idx == CFG_RATE), (r_qlast == '0) && (r_t0 == $past(r_last)), "rate write did not re-anchor")
    `TBP_ASSERT_IMP(a_rem_bound, 1'b1, r_rem < BPB_MICROS, "refill remainder out of range")

endmodule

@@ src/token_bucket_policer.sv @@
// Channel   Dir  Payload                                             Handshake
// i_pkt     in   packet_bytes[15:0], now_micros[63:0]                valid/ready
// o_res     out  allowed, outcome[1:0], tokens_before[31:0],         valid/ready
//                tokens_after[31:0], refill_bytes[41:0]
// i_cfg_*   in   index[1:0], data[39:0]                              write enable
//
// One beat per cycle unless the output stalls; a verdict leaves 15 register stages
// after its beat. The product pipeline (4 stages) and five digit stages of the
// divider (2 each) carry no state; only the final bucket stage updates the bucket.
// Output stalls ripple back through per-stage valid bits, so bubbles still fill.
// Synchronous active-low reset empties the pipe and zeroes bucket and registers.
module token_bucket_policer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tbp_pkt_if.sink                        i_pkt,
    tbp_res_if.source                      o_res
);
    import tbp_pkg::*;

    logic    w_v   [DIG_N+1];
    logic    w_rdy [DIG_N+1];
    t_div    w_d   [DIG_N+1];
    t_anchor w_anc;

    // Refill numerator
    tbp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (i_pkt),
        .i_anc   (w_anc),
        .o_valid (w_v[0]),
        .o_data  (w_d[0]),
        .i_ready (w_rdy[0])
    );

    // Division by 15625, one digit per step
    for (genvar g = 0; g < DIG_N; g++) begin : g_div
        tbp_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_rdy[g]),
            .i_data  (w_d[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_data  (w_d[g+1])
        );
    end

    // Bucket state, configuration and verdict
    tbp_bucket u_bucket (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (w_v[DIG_N]),
        .o_ready    (w_rdy[DIG_N]),
        .i_data     (w_d[DIG_N]),
        .o_anc      (w_anc),
        .o_res      (o_res)
    );

endmodule

@@ bench/tbp_checker.sv @@
`timescale 1ns / 1ps

// Watches the packet, verdict and register ports of the policer, keeps its own
// bucket, and compares every verdict beat with the oldest one it predicted.
module tbp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tbp_pkt_if                             i_pkt,
    tbp_res_if                             i_res,
    output int                             o_fail_count,
    output int                             o_pending
);
    import tbp_pkg::*;

    localparam logic [TIME_W-1:0] BIT_MICROS_PER_BYTE = 64'd8_000_000;
    localparam int                MAX_REPORTS         = 10;

    typedef struct packed {
        logic                allowed;
        t_outcome            outcome;
        logic [LEVEL_W-1:0]  tokens_before;
        logic [LEVEL_W-1:0]  tokens_after;
        logic [REFILL_W-1:0] refill_bytes;
    } t_verdict;

    // Register copies
    logic                gate_q;
    logic [RATE_W-1:0]   rate_q;
    logic [LEVEL_W-1:0]  burst_q;

    // Bucket copy
    logic [LEVEL_W-1:0]  level_q;
    logic [TIME_W-1:0]   anchor_time_q;
    logic [REM_W-1:0]    carry_q;

    t_verdict            verdicts_due[$];
    int                  fail_cnt = 0;

    // Refill, clamp and charge for one packet; commits the bucket unless rejected early
    function automatic t_verdict judge_packet(input logic [PKT_W-1:0]  pkt,
                                              input logic [TIME_W-1:0] now);
        t_verdict            v;
        logic [TIME_W-1:0]   elapsed;
        logic [PROD_W-1:0]   product;
        logic [TIME_W:0]     numer;
        logic [TIME_W-1:0]   refill;
        logic [TIME_W-1:0]   room;
        logic [LEVEL_W-1:0]  level;

        v.allowed       = 1'b0;
        v.outcome       = OUT_GATE;
        v.tokens_before = level_q;
        v.tokens_after  = level_q;
        v.refill_bytes  = '0;
        if (gate_q) return v;

        // time going backwards or a numerator past 64 bits
        v.outcome = OUT_ARITH;
        if (now < anchor_time_q) return v;
        elapsed = now - anchor_time_q;
        product = PROD_W'(elapsed) * PROD_W'(rate_q);
        if (product[PROD_W-1:TIME_W] != '0) return v;
        numer = {1'b0, product[TIME_W-1:0]} + (TIME_W+1)'(carry_q);
        if (numer[TIME_W]) return v;

        refill        = numer[TIME_W-1:0] / BIT_MICROS_PER_BYTE;
        carry_q       = REM_W'(numer[TIME_W-1:0] % BIT_MICROS_PER_BYTE);
        anchor_time_q = now;

        // no room when the level already sits above a lowered burst
        room  = (burst_q > level_q) ? TIME_W'(burst_q - level_q) : '0;
        level = level_q + LEVEL_W'((refill < room) ? refill : room);
        v.refill_bytes = refill[REFILL_W-1:0];

        if (LEVEL_W'(pkt) > level) begin
            v.outcome = OUT_LIMITED;
        end else begin
            level     = level - LEVEL_W'(pkt);
            v.allowed = 1'b1;
            v.outcome = OUT_ALLOW;
        end
        v.tokens_after = level;
        level_q        = level;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;

        if (!i_rst_n) begin
            gate_q        = 1'b0;
            rate_q        = '0;
            burst_q       = '0;
            level_q       = '0;
            anchor_time_q = '0;
            carry_q       = '0;
            verdicts_due.delete();
        end else begin
            // register writes; unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GATE:  gate_q  = i_cfg_data[0];
                    CFG_RATE:  rate_q  = i_cfg_data[RATE_W-1:0];
                    CFG_BURST: burst_q = i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end

            // verdict beat against the oldest prediction
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                if (verdicts_due.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("verdict beat with nothing predicted: allowed=%0d outcome=%0d",
                                 i_res.allowed, i_res.outcome);
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_res.allowed !== want.allowed || i_res.outcome !== want.outcome ||
                        i_res.tokens_before !== want.tokens_before ||
                        i_res.tokens_after !== want.tokens_after ||
                        i_res.refill_bytes !== want.refill_bytes) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS) begin
                            $display("verdict mismatch at %0t", $realtime);
                            $display("  expected allowed=%0d outcome=%0d before=%0d after=%0d refill=%0d",
                                     want.allowed, want.outcome, want.tokens_before,
                                     want.tokens_after, want.refill_bytes);
                            $display("  got      allowed=%0d outcome=%0d before=%0d after=%0d refill=%0d",
                                     i_res.allowed, i_res.outcome, i_res.tokens_before,
                                     i_res.tokens_after, i_res.refill_bytes);
                        end
                    end
                end
            end

            // packet beat
            if (i_pkt.valid === 1'b1 && i_pkt.ready === 1'b1)
                verdicts_due.push_back(judge_packet(i_pkt.packet_bytes, i_pkt.now_micros));
        end
        o_pending    <= verdicts_due.size();
        o_fail_count <= fail_cnt;
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import tbp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;  // index past the register list
    localparam int                   PIPE_DEPTH = 15;

    typedef enum {RX_OPEN, RX_COIN, RX_PATTERN, RX_BLOCKS} t_rx_mode;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    logic [TIME_W-1:0]     t_cur;
    int                    burst_left;

    t_rx_mode              rx_mode = RX_OPEN;
    int                    mode_left = 0;
    int                    run_left = 0;
    int                    beat_phase = 0;

    tbp_pkt_if pkt_if ();
    tbp_res_if res_if ();

    token_bucket_policer uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pkt      (pkt_if),
        .o_res      (res_if)
    );

    tbp_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_pkt        (pkt_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Verdict side backpressure: a random mode is held for a random run, then redrawn
    always @(posedge clk) begin
        beat_phase <= beat_phase + 1;
        if (mode_left == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(3, 0));
            mode_left <= $urandom_range(400, 50);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:    res_if.ready <= 1'b1;
            RX_COIN:    res_if.ready <= 1'($urandom_range(1, 0));
            RX_PATTERN: res_if.ready <= (beat_phase % 7) < 4;
            default: begin
                if (run_left == 0) begin
                    res_if.ready <= !res_if.ready;
                    run_left     <= $urandom_range(20, 1);
                end else begin
                    run_left <= run_left - 1;
                end
            end
        endcase
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One packet beat; the sender idles between bursts of random length
    task automatic send_packet(input logic [PKT_W-1:0] len, input logic [TIME_W-1:0] stamp);
        int gap;

        pkt_if.valid        <= 1'b1;
        pkt_if.packet_bytes <= len;
        pkt_if.now_micros   <= stamp;
        do @(posedge clk); while (pkt_if.ready !== 1'b1);
        if (stamp > t_cur) t_cur = stamp;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(8, 1);
            pkt_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 60)
                                                     : $urandom_range(16, 0);
        end
    endtask

    // Hold off until every verdict is back and the pipe has emptied
    task automatic wait_drained();
        pkt_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 5) @(posedge clk);
    endtask

    // Mostly steady timestamps, plus backward stamps, long jumps and odd lengths
    task automatic run_traffic(input int n, input int unsigned max_delta,
                               input int unsigned max_pkt);
        int unsigned       roll;
        logic [TIME_W-1:0] stamp;
        logic [PKT_W-1:0]  len;

        for (int k = 0; k < n; k++) begin
            roll  = $urandom_range(99, 0);
            len   = PKT_W'($urandom_range(max_pkt, 0));
            stamp = t_cur + TIME_W'($urandom_range(max_delta, 0));
            if (roll >= 94)
                stamp = {1'b0, 63'({$urandom, $urandom})};
            else if (roll >= 88)
                stamp = t_cur + ({$urandom, $urandom} >> $urandom_range(40, 8));
            else if (roll >= 82)
                len = PKT_W'($urandom);
            send_packet(len, stamp);
        end
    endtask

    initial begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        pkt_if.valid        <= 1'b0;
        pkt_if.packet_bytes <= '0;
        pkt_if.now_micros   <= '0;
        t_cur      = '0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty bucket, zero rate: only a zero length fits
        send_packet(16'd0, 64'd0);
        send_packet(16'd1, 64'd0);
        send_packet(16'hFFFF, 64'd1);
        wait_drained();

        // masked writes and a write to an unused index
        write_reg(CFG_RATE, 40'd3);
        write_reg(CFG_BURST, 40'hFF_FFFF_FFFF);
        write_reg(CFG_GATE, 40'hFF_FFFF_FFFE);
        write_reg(CFG_SPARE, 40'hFF_FFFF_FFFF);

        // carried remainder, then overflow on adding it, on the product, and a backward stamp
        send_packet(16'd0, 64'd6);
        send_packet(16'd0, 64'd6 + 64'h5555_5555_5555_5555);
        send_packet(16'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_packet(16'd0, 64'd5);
        wait_drained();

        // closed gate wins over everything
        write_reg(CFG_GATE, 40'd1);
        send_packet(16'd100, 64'd100);
        send_packet(16'd0, 64'd0);
        wait_drained();

        // top rate: full refill clamped, charge, empty refill, product limit either side
        write_reg(CFG_GATE, 40'd0);
        write_reg(CFG_RATE, 40'hFF_FFFF_FFFF);
        write_reg(CFG_BURST, 40'd70000);
        send_packet(16'hFFFF, 64'd7);
        send_packet(16'hFFFF, 64'd7);
        send_packet(16'd0, 64'd7 + 64'd16777217);
        send_packet(16'd0, 64'd7 + 64'd16777216);
        wait_drained();

        // burst lowered under the level: no refill, level kept
        write_reg(CFG_BURST, 40'd10);
        send_packet(16'd5, 64'd16777224);
        send_packet(16'hFFFF, 64'd16777224);
        wait_drained();

        // zero rate allows any elapsed time; move the clock high
        write_reg(CFG_RATE, 40'd0);
        write_reg(CFG_BURST, 40'hFF_FFFF_FFFF);
        send_packet(16'd0, {2'b10, 30'($urandom), 32'($urandom)});
        t_cur = pkt_if.now_micros;
        wait_drained();

        // one byte per microsecond into a small bucket
        write_reg(CFG_RATE, 40'd8_000_000);
        write_reg(CFG_BURST, 40'd3000);
        run_traffic(250, 2000, 1500);
        wait_drained();

        // extremes of rate and burst
        write_reg(CFG_RATE, 40'hFF_FFFF_FFFF);
        write_reg(CFG_BURST, 40'hFF_FFFF_FFFF);
        run_traffic(150, 50, 65535);
        wait_drained();

        // random rate and burst
        write_reg(CFG_RATE, {8'($urandom), 32'($urandom)});
        write_reg(CFG_BURST, 40'($urandom));
        run_traffic(200, 1000, 65535);
        wait_drained();

        // gate closed
        write_reg(CFG_GATE, 40'd1);
        write_reg(CFG_RATE, {8'($urandom), 32'($urandom)});
        run_traffic(80, 1000, 65535);
        wait_drained();

        // nothing ever refills
        write_reg(CFG_GATE, 40'd0);
        write_reg(CFG_RATE, 40'd0);
        write_reg(CFG_BURST, 40'd0);
        run_traffic(60, 1000, 3);
        wait_drained();

        // moderate rates, remainders carried
        write_reg(CFG_RATE, 40'($urandom_range(100_000_000, 1)));
        write_reg(CFG_BURST, 40'($urandom_range(100000, 1)));
        run_traffic(220, 5000, 2000);
        wait_drained();

        // fill a deep bucket, then cut the burst under the level
        write_reg(CFG_RATE, 40'd8_000_000_000);
        write_reg(CFG_BURST, 40'hFF_FFFF_FFFF);
        run_traffic(30, 2000, 100);
        wait_drained();
        write_reg(CFG_BURST, 40'd500);
        run_traffic(40, 2000, 65535);
        wait_drained();

        if (fail_count == 0 && pending == 0) begin
            $display("token_bucket_policer: match");
        end else begin
            $display("token_bucket_policer: mismatch");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("token_bucket_policer: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/tbp_pkg.sv
src/tbp_if.sv
src/tbp_mul.sv
src/tbp_div_step.sv
src/tbp_bucket.sv
src/token_bucket_policer.sv
bench/tbp_checker.sv
bench/testbench.sv
